### rtl/stlp_pkg.sv
// Shared constants, types and the saturating delay function for the latency probe.
package stlp_pkg;

    // DNS query slot count and derived widths
    localparam int DNS_SLOTS = 16;
    localparam int CNT_W     = $clog2(DNS_SLOTS + 1);
    localparam int IDX_W     = (DNS_SLOTS > 1) ? $clog2(DNS_SLOTS) : 1;

    // Protocol and flag codes
    localparam logic [7:0] PROTO_UDP  = 8'h11;
    localparam logic [7:0] FLG_SYN    = 8'h02;
    localparam logic [7:0] FLG_SYNACK = 8'h12;
    localparam logic [7:0] FLG_ACK    = 8'h10;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_DNS_RESPONSE_FLAGS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_MARKER        = 1'b1;
    localparam logic [15:0] DNS_RESPONSE_FLAGS_RST = 16'h8081;
    localparam logic [31:0] PLAY_MARKER_RST        = 32'h7004_0002;

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 96;

    // Input request, packed first field in the high bits
    typedef struct packed {
        logic [31:0] payload_word;
        logic [7:0]  tcp_flags;
        logic [15:0] dns_flags;
        logic [7:0]  ip_protocol;
        logic [63:0] timestamp_us;
    } item_t;

    // Result request, packed first field in the high bits
    typedef struct packed {
        logic [31:0] play_delay_us;
        logic [31:0] tcp_delay_us;
        logic [31:0] dns_delay_us;
    } result_t;

    // DNS tracker status toward the handshake tracker
    typedef struct packed {
        logic        done;
        logic [31:0] delay;
    } dns_status_t;

    // end - start, zero when negative, saturated to 32 bits
    function automatic logic [31:0] sat_delay(input logic [63:0] t_start,
                                              input logic [63:0] t_end);
        logic [64:0] diff;
        diff = {1'b0, t_end} - {1'b0, t_start};
        if (diff[64])
            sat_delay = 32'd0;
        else if (|diff[63:32])
            sat_delay = 32'hFFFF_FFFF;
        else
            sat_delay = diff[31:0];
    endfunction

endpackage

### rtl/stlp_dns.sv
// DNS query slots and response pairing; produces the DNS delay.
module stlp_dns (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  clear,
    input  logic [63:0]           timestamp_us,
    input  logic [7:0]            ip_protocol,
    input  logic [15:0]           dns_flags,
    input  logic [15:0]           resp_flags,
    output stlp_pkg::dns_status_t status
);

    logic [63:0]                    query_times [stlp_pkg::DNS_SLOTS];
    logic [stlp_pkg::DNS_SLOTS-1:0] query_valid_reg, query_valid_next;
    logic [stlp_pkg::CNT_W-1:0]     query_cnt_reg, query_cnt_next;
    logic [stlp_pkg::CNT_W-1:0]     resp_cnt_reg, resp_cnt_next;
    logic                           done_reg, done_next;
    logic [31:0]                    delay_reg, delay_next;

    logic is_udp, is_resp, query_room, resp_room, hit, do_query;
    logic [stlp_pkg::IDX_W-1:0] q_idx, r_idx;

    assign is_udp     = (ip_protocol == stlp_pkg::PROTO_UDP);
    assign is_resp    = (dns_flags == resp_flags);
    assign query_room = (query_cnt_reg < stlp_pkg::CNT_W'(stlp_pkg::DNS_SLOTS));
    assign resp_room  = (resp_cnt_reg < stlp_pkg::CNT_W'(stlp_pkg::DNS_SLOTS));
    assign q_idx      = query_cnt_reg[stlp_pkg::IDX_W-1:0];
    assign r_idx      = resp_cnt_reg[stlp_pkg::IDX_W-1:0];
    assign hit        = query_valid_reg[r_idx];
    assign do_query   = step && is_udp && !is_resp && query_room;

    always_comb
    begin
        query_valid_next = query_valid_reg;
        query_cnt_next   = query_cnt_reg;
        resp_cnt_next    = resp_cnt_reg;
        done_next        = done_reg;
        delay_next       = delay_reg;
        if (clear)
        begin
            query_valid_next = '0;
            query_cnt_next   = '0;
            resp_cnt_next    = '0;
            done_next        = 1'b0;
            delay_next       = '0;
        end
        else if (step && is_udp)
        begin
            if (is_resp)
            begin
                if (resp_room)
                begin
                    if (hit)
                    begin
                        delay_next       = stlp_pkg::sat_delay(query_times[r_idx],
                                                               timestamp_us);
                        done_next        = 1'b1;
                        query_valid_next = '0;
                        query_cnt_next   = '0;
                        resp_cnt_next    = '0;
                    end
                    else
                    begin
                        resp_cnt_next = resp_cnt_reg + 1'b1;
                    end
                end
            end
            else if (query_room)
            begin
                query_valid_next[q_idx] = 1'b1;
                query_cnt_next          = query_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_valid_reg <= '0;
            query_cnt_reg   <= '0;
            resp_cnt_reg    <= '0;
            done_reg        <= 1'b0;
            delay_reg       <= '0;
        end
        else
        begin
            query_valid_reg <= query_valid_next;
            query_cnt_reg   <= query_cnt_next;
            resp_cnt_reg    <= resp_cnt_next;
            done_reg        <= done_next;
            delay_reg       <= delay_next;
        end
    end

    // slot timestamps: no reset, read only behind a valid bit
    always_ff @(posedge clk)
    begin
        if (do_query)
            query_times[q_idx] <= timestamp_us;
    end

    assign status.done  = done_reg;
    assign status.delay = delay_reg;

endmodule

### rtl/stlp_tcp.sv
// TCP handshake timing and play marker detection.
module stlp_tcp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [63:0] timestamp_us,
    input  logic [7:0]  tcp_flags,
    input  logic [31:0] payload_word,
    input  logic [31:0] play_marker,
    output logic        play,
    output logic [31:0] tcp_delay_us,
    output logic [31:0] play_delay_us
);

    logic [63:0] syn_time_reg, syn_time_next;
    logic        syn_seen_reg, syn_seen_next;
    logic        synack_seen_reg, synack_seen_next;
    logic [63:0] ack_time_reg, ack_time_next;
    logic        ack_seen_reg, ack_seen_next;
    logic [31:0] shake_delay_reg, shake_delay_next;

    logic is_syn, is_synack, ack_hit, ack_now;
    logic [31:0] hs_delay, ack_play_delay;

    assign is_syn    = (tcp_flags == stlp_pkg::FLG_SYN);
    assign is_synack = (tcp_flags == stlp_pkg::FLG_SYNACK);
    assign ack_hit   = (tcp_flags == stlp_pkg::FLG_ACK) && syn_seen_reg &&
                       synack_seen_reg && !ack_seen_reg;
    assign ack_now   = ack_seen_reg || ack_hit;

    assign hs_delay       = stlp_pkg::sat_delay(syn_time_reg, timestamp_us);
    assign ack_play_delay = stlp_pkg::sat_delay(ack_time_reg, timestamp_us);

    // an ACK that also carries play gives zero play delay
    assign tcp_delay_us  = ack_hit ? hs_delay : shake_delay_reg;
    assign play_delay_us = ack_hit ? 32'd0 : ack_play_delay;
    assign play          = step && ack_now && (payload_word == play_marker);

    always_comb
    begin
        syn_time_next    = syn_time_reg;
        syn_seen_next    = syn_seen_reg;
        synack_seen_next = synack_seen_reg;
        ack_time_next    = ack_time_reg;
        ack_seen_next    = ack_seen_reg;
        shake_delay_next = shake_delay_reg;
        if (play)
        begin
            syn_time_next    = '0;
            syn_seen_next    = 1'b0;
            synack_seen_next = 1'b0;
            ack_time_next    = '0;
            ack_seen_next    = 1'b0;
            shake_delay_next = '0;
        end
        else if (step)
        begin
            if (is_syn)
            begin
                syn_time_next = timestamp_us;
                syn_seen_next = 1'b1;
            end
            if (is_synack && syn_seen_reg)
                synack_seen_next = 1'b1;
            if (ack_hit)
            begin
                ack_time_next    = timestamp_us;
                ack_seen_next    = 1'b1;
                shake_delay_next = hs_delay;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            syn_time_reg    <= '0;
            syn_seen_reg    <= 1'b0;
            synack_seen_reg <= 1'b0;
            ack_time_reg    <= '0;
            ack_seen_reg    <= 1'b0;
            shake_delay_reg <= '0;
        end
        else
        begin
            syn_time_reg    <= syn_time_next;
            syn_seen_reg    <= syn_seen_next;
            synack_seen_reg <= synack_seen_next;
            ack_time_reg    <= ack_time_next;
            ack_seen_reg    <= ack_seen_next;
            shake_delay_reg <= shake_delay_next;
        end
    end

endmodule

### rtl/stream_setup_latency_probe_core.sv
// Top level of the stream setup latency probe: input/output registers, config, trackers.
//
//  Channel  | Direction | Moves                          | Handshake
//  ---------+-----------+--------------------------------+--------------------
//  s_axis   | in        | one parsed packet request       | tvalid/tready
//  m_axis   | out       | three delays, only at play      | tvalid/tready
//  cfg      | in        | register write (index 0 or 1)   | cfg_we, no wait
//
// One request per cycle sustained while the sink keeps up. A taken request sits
// in the input register and is processed once the output can take a result.
// Processing updates the DNS and TCP trackers, and a result (if play was hit)
// loads the output register, which drives m_axis_tvalid.
// While a result waits on a stalled output, the input register holds and
// s_axis_tready drops, also for requests that would make no result.
// Reset (rst_n low, async) clears all tracker state and loads config defaults.
module stream_setup_latency_probe_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // timestamp_us[63:0], ip_protocol[71:64], dns_flags[87:72],
    // tcp_flags[95:88], payload_word[127:96]
    input  logic [stlp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // dns_delay_us[31:0], tcp_delay_us[63:32], play_delay_us[95:64]
    output logic [stlp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [stlp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stlp_pkg::CFG_DATA_W-1:0] cfg_data
);

    // config registers
    logic [15:0] resp_flags_reg;
    logic [31:0] play_marker_reg;

    // input register
    logic            in_vld_reg, in_vld_next;
    stlp_pkg::item_t in_data_reg;

    // output register
    logic              out_vld_reg, out_vld_next;
    stlp_pkg::result_t out_data_reg;

    logic                  fire, tcp_step, play;
    logic [31:0]           shake_delay, play_delay;
    stlp_pkg::dns_status_t dns_stat;

    // a request in the input register is processed when the output can take a result
    assign fire          = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || fire;
    assign tcp_step      = fire && (in_data_reg.ip_protocol != stlp_pkg::PROTO_UDP) &&
                           dns_stat.done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_flags_reg  <= stlp_pkg::DNS_RESPONSE_FLAGS_RST;
            play_marker_reg <= stlp_pkg::PLAY_MARKER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stlp_pkg::REG_DNS_RESPONSE_FLAGS: resp_flags_reg  <= cfg_data[15:0];
                stlp_pkg::REG_PLAY_MARKER:        play_marker_reg <= cfg_data[31:0];
                default:                          ;
            endcase
        end
    end

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_axis_tready)
            in_vld_next = s_axis_tvalid;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_vld_reg && m_axis_tready)
            out_vld_next = 1'b0;
        if (play)
            out_vld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_data_reg <= s_axis_tdata;
        if (play)
        begin
            out_data_reg.dns_delay_us  <= dns_stat.delay;
            out_data_reg.tcp_delay_us  <= shake_delay;
            out_data_reg.play_delay_us <= play_delay;
        end
    end

    stlp_dns u_dns (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (fire),
        .clear        (play),
        .timestamp_us (in_data_reg.timestamp_us),
        .ip_protocol  (in_data_reg.ip_protocol),
        .dns_flags    (in_data_reg.dns_flags),
        .resp_flags   (resp_flags_reg),
        .status       (dns_stat)
    );

    stlp_tcp u_tcp (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (tcp_step),
        .timestamp_us  (in_data_reg.timestamp_us),
        .tcp_flags     (in_data_reg.tcp_flags),
        .payload_word  (in_data_reg.payload_word),
        .play_marker   (play_marker_reg),
        .play          (play),
        .tcp_delay_us  (shake_delay),
        .play_delay_us (play_delay)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // play only after a DNS match
    a_play_needs_dns: assert property (@(posedge clk) disable iff (!rst_n)
        play |-> dns_stat.done)
        else $error("play result without completed DNS measurement");

    // play returns the DNS tracker to its reset state
    a_play_clears_dns: assert property (@(posedge clk) disable iff (!rst_n)
        play |=> !dns_stat.done)
        else $error("DNS state not cleared after play");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !m_axis_tready) |-> !fire)
        else $error("request processed while result stalled");

    // input side only pushes back with a request held
    a_ready_low_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_vld_reg)
        else $error("input not ready while input register empty");

endmodule
